// ===== hdl/gaps_pkg.sv =====
package gaps_pkg;

    // map geometry, fixed by the 6-bit coordinate fields
    localparam int MAP_SIDE = 64;
    localparam int COORD_W  = 6;
    localparam int IDX_W    = 2 * COORD_W;
    localparam int CELLS    = MAP_SIDE * MAP_SIDE;
    localparam int CNT_W    = IDX_W + 1;
    localparam int DIM_W    = 7;

    localparam int COST_BITS_DEF = 17;
    localparam int OUT_COST_W    = 17;
    localparam int H_W           = 10;

    localparam int STEP_ORTHO = 10;
    localparam int STEP_DIAG  = 14;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;
    localparam int USER_W   = 2;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_PATH = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_END     = 2'd3
    } status_t;

    typedef enum logic {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } map_cfg_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_RD_RD,
        S_RD_WR,
        S_CLR,
        S_START_RD,
        S_START_WR,
        S_CHECK,
        S_SCAN,
        S_MOVE,
        S_CLOSE,
        S_NB_RD,
        S_NB_WR,
        S_RESP
    } state_t;

    // neighbour order n, e, s, w, ne, se, sw, nw
    function automatic logic [1:0] move_dx(input logic [2:0] k);
        logic [1:0] d;
        case (k)
            3'd1, 3'd4, 3'd5: d = 2'b01;
            3'd3, 3'd6, 3'd7: d = 2'b11;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] move_dy(input logic [2:0] k);
        logic [1:0] d;
        case (k)
            3'd0, 3'd4, 3'd7: d = 2'b11;
            3'd2, 3'd5, 3'd6: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

    // octile distance, at most 14 * 63
    function automatic logic [H_W-1:0] octile(
        input logic [COORD_W-1:0] ax,
        input logic [COORD_W-1:0] ay,
        input logic [COORD_W-1:0] bx,
        input logic [COORD_W-1:0] by
    );
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic [H_W-1:0]     lo_e;
        logic [H_W-1:0]     df_e;
        dx   = (ax > bx) ? (ax - bx) : (bx - ax);
        dy   = (ay > by) ? (ay - by) : (by - ay);
        lo   = (dx < dy) ? dx : dy;
        hi   = (dx < dy) ? dy : dx;
        lo_e = {{(H_W-COORD_W){1'b0}}, lo};
        df_e = {{(H_W-COORD_W){1'b0}}, hi - lo};
        return (lo_e * H_W'(STEP_DIAG)) + (df_e * H_W'(STEP_ORTHO));
    endfunction

endpackage

// ===== hdl/gaps_ram.sv =====
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/gaps_cfg.sv =====
module gaps_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gaps_pkg::APB_AW-1:0]  paddr,
    input  logic [gaps_pkg::APB_DW-1:0]  pwdata,
    output logic [gaps_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output gaps_pkg::map_cfg_t           cfg
);
    import gaps_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             wr_en;
    reg_idx_t         sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = reg_idx_t'(paddr[APB_AW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAP_SIDE);
            height_reg <= DIM_W'(MAP_SIDE);
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_MAP_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_MAP_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:        width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_MAP_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, width_reg};
            REG_MAP_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, height_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

// ===== hdl/gaps_ctrl.sv =====
module gaps_ctrl #(
    parameter int COST_BITS = gaps_pkg::COST_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gaps_pkg::map_cfg_t             cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gaps_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [gaps_pkg::USER_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gaps_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [gaps_pkg::USER_W-1:0]    m_tuser,
    output logic                           m_tlast
);
    import gaps_pkg::*;

    typedef struct packed {
        logic                 blk;
        logic                 is_open;
        logic                 is_closed;
        logic                 pvalid;
        logic [IDX_W-1:0]     parent;
        logic [COST_BITS-1:0] g;
        logic [COST_BITS-1:0] f;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    function automatic logic [COST_BITS-1:0] sat_add(
        input logic [COST_BITS-1:0] a,
        input logic [COST_BITS-1:0] b
    );
        logic [COST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_BITS] ? {COST_BITS{1'b1}} : s[COST_BITS-1:0];
    endfunction

    // memory ports
    logic              cell_we;
    logic [IDX_W-1:0]  cell_waddr;
    cell_t             cell_wdata;
    logic              cell_re;
    logic [IDX_W-1:0]  cell_raddr;
    logic [CELL_W-1:0] cell_rbits;
    cell_t             cell_rdata;
    logic              q_we;
    logic [IDX_W-1:0]  q_waddr;
    logic [IDX_W-1:0]  q_wdata;
    logic [IDX_W-1:0]  q_raddr;
    logic [IDX_W-1:0]  q_rdata;

    gaps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rbits)
    );

    gaps_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign cell_rdata = cell_t'(cell_rbits);

    // control registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic              p1_vld_reg, p1_vld_next;
    logic              p2_vld_reg, p2_vld_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              cursor_vld_reg, cursor_vld_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [2:0]        k_reg, k_next;
    logic [3:0]        ok_reg, ok_next;

    // payload registers
    logic [IDX_W-1:0]     cursor_idx_reg, cursor_idx_next;
    logic [IDX_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [IDX_W-1:0]     p1_i_reg, p1_i_next;
    logic [IDX_W-1:0]     p2_i_reg, p2_i_next;
    logic [IDX_W-1:0]     p2_idx_reg, p2_idx_next;
    logic [IDX_W-1:0]     best_i_reg, best_i_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    cell_t                best_word_reg, best_word_next;
    logic [IDX_W-1:0]     ld_idx_reg, ld_idx_next;
    logic                 ld_blk_reg, ld_blk_next;
    logic [COORD_W-1:0]   goal_x_reg, goal_x_next;
    logic [COORD_W-1:0]   goal_y_reg, goal_y_next;
    logic [H_W-1:0]       h_reg, h_next;
    logic                 nb_in_reg, nb_in_next;
    logic [IDX_W-1:0]     nb_idx_reg, nb_idx_next;
    status_t              res_status_reg, res_status_next;
    logic [COORD_W-1:0]   res_x_reg, res_x_next;
    logic [COORD_W-1:0]   res_y_reg, res_y_next;
    logic                 res_last_reg, res_last_next;
    logic [OUT_COST_W-1:0] res_cost_reg, res_cost_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [USER_W-1:0]    m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    // input fields
    cmd_t               in_cmd;
    logic [COORD_W-1:0] in_tx;
    logic [COORD_W-1:0] in_ty;
    logic               in_blk;
    logic [COORD_W-1:0] in_gx;
    logic [COORD_W-1:0] in_gy;

    assign in_cmd = cmd_t'(s_tuser);
    assign in_tx  = s_tdata[COORD_W-1:0];
    assign in_ty  = s_tdata[2*COORD_W-1:COORD_W];
    assign in_blk = s_tdata[2*COORD_W];
    assign in_gx  = s_tdata[3*COORD_W:2*COORD_W+1];
    assign in_gy  = s_tdata[4*COORD_W:3*COORD_W+1];

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              s_acc;
    logic              srch_ok;
    logic [CNT_W-1:0]  cnt_inc;
    logic              scan_done;
    logic              move_more;
    logic              move_done;
    logic              clr_done;
    logic              out_free;
    logic              out_load;
    logic              is_goal;

    assign w_eff   = (cfg.width  > DIM_W'(MAP_SIDE)) ? DIM_W'(MAP_SIDE) : cfg.width;
    assign h_eff   = (cfg.height > DIM_W'(MAP_SIDE)) ? DIM_W'(MAP_SIDE) : cfg.height;
    assign s_acc   = s_tvalid && s_tready;
    assign srch_ok = ({1'b0, in_tx} < w_eff) && ({1'b0, in_ty} < h_eff)
                  && ({1'b0, in_gx} < w_eff) && ({1'b0, in_gy} < h_eff);
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign scan_done = (cnt_reg == count_reg) && !p1_vld_reg && !p2_vld_reg;
    assign move_more = cnt_inc < count_reg;
    assign move_done = !move_more && !pend_reg;
    assign clr_done  = cnt_reg[IDX_W] && !pend_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == S_RESP) && out_free;
    assign is_goal   = best_idx_reg == {goal_y_reg, goal_x_reg};

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // neighbour geometry
    logic [1:0]         nb_dx;
    logic [1:0]         nb_dy;
    logic [COORD_W+1:0] nb_x8;
    logic [COORD_W+1:0] nb_y8;
    logic               nb_range;

    assign nb_dx    = move_dx(k_reg);
    assign nb_dy    = move_dy(k_reg);
    assign nb_x8    = {2'b00, best_idx_reg[COORD_W-1:0]} + {{COORD_W{nb_dx[1]}}, nb_dx};
    assign nb_y8    = {2'b00, best_idx_reg[IDX_W-1:COORD_W]} + {{COORD_W{nb_dy[1]}}, nb_dy};
    assign nb_range = !nb_x8[COORD_W+1] && (nb_x8[DIM_W-1:0] < w_eff)
                   && !nb_y8[COORD_W+1] && (nb_y8[DIM_W-1:0] < h_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (cnt_reg[IDX_W])
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_acc)
                begin
                    unique case (in_cmd)
                        CMD_LOAD:   state_next = S_LD_RD;
                        CMD_SEARCH: state_next = srch_ok ? S_CLR : S_RESP;
                        CMD_READ:   state_next = cursor_vld_reg ? S_RD_RD : S_RESP;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_LD_RD:    state_next = S_LD_WR;
            S_LD_WR:    state_next = S_RESP;
            S_RD_RD:    state_next = S_RD_WR;
            S_RD_WR:    state_next = S_RESP;
            S_CLR:
            begin
                if (clr_done)
                begin
                    state_next = S_START_RD;
                end
            end
            S_START_RD: state_next = S_START_WR;
            S_START_WR: state_next = S_CHECK;
            S_CHECK:    state_next = (count_reg == '0) ? S_RESP : S_SCAN;
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (move_done)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:    state_next = is_goal ? S_RESP : S_NB_RD;
            S_NB_RD:    state_next = S_NB_WR;
            S_NB_WR:    state_next = (k_reg == 3'd7) ? S_CHECK : S_NB_RD;
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cell_t               nw;
        logic                walk;
        logic                ok_k;
        logic [COST_BITS-1:0] tg;
        logic [COST_BITS-1:0] step;
        logic [COST_BITS-1:0] h_ext;

        nw    = cell_rdata;
        walk  = 1'b0;
        ok_k  = 1'b0;
        step  = k_reg[2] ? COST_BITS'(STEP_DIAG) : COST_BITS'(STEP_ORTHO);
        h_ext = {{(COST_BITS-H_W){1'b0}}, h_reg};
        tg    = sat_add(best_word_reg.g, step);

        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = '0;
        cell_re    = 1'b0;
        cell_raddr = '0;
        q_we       = 1'b0;
        q_waddr    = '0;
        q_wdata    = '0;
        q_raddr    = '0;

        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        p1_vld_next     = p1_vld_reg;
        p1_i_next       = p1_i_reg;
        p2_vld_next     = p2_vld_reg;
        p2_i_next       = p2_i_reg;
        p2_idx_next     = p2_idx_reg;
        count_next      = count_reg;
        cursor_vld_next = cursor_vld_reg;
        cursor_idx_next = cursor_idx_reg;
        k_next          = k_reg;
        ok_next         = ok_reg;
        best_i_next     = best_i_reg;
        best_idx_next   = best_idx_reg;
        best_word_next  = best_word_reg;
        ld_idx_next     = ld_idx_reg;
        ld_blk_next     = ld_blk_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        h_next          = h_reg;
        nb_in_next      = nb_in_reg;
        nb_idx_next     = nb_idx_reg;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_last_next   = res_last_reg;
        res_cost_next   = res_cost_reg;

        case (state_reg)
            S_INIT:
            begin
                // wipe the map to walkable after reset
                if (!cnt_reg[IDX_W])
                begin
                    cell_we    = 1'b1;
                    cell_waddr = cnt_reg[IDX_W-1:0];
                    cnt_next   = cnt_inc;
                end
            end
            S_IDLE:
            begin
                if (s_acc)
                begin
                    ld_idx_next     = {in_ty, in_tx};
                    ld_blk_next     = in_blk;
                    goal_x_next     = in_gx;
                    goal_y_next     = in_gy;
                    best_idx_next   = {in_ty, in_tx};
                    h_next          = octile(in_tx, in_ty, in_gx, in_gy);
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    res_status_next = STAT_OK;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_last_next   = 1'b0;
                    res_cost_next   = '0;
                    case (in_cmd)
                        CMD_SEARCH:
                        begin
                            cursor_vld_next = 1'b0;
                            if (!srch_ok)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!cursor_vld_reg)
                            begin
                                res_status_next = STAT_END;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_LD_RD:
            begin
                cell_re    = 1'b1;
                cell_raddr = ld_idx_reg;
            end
            S_LD_WR:
            begin
                nw.blk     = ld_blk_reg;
                cell_we    = 1'b1;
                cell_waddr = ld_idx_reg;
                cell_wdata = nw;
            end
            S_RD_RD:
            begin
                cell_re    = 1'b1;
                cell_raddr = cursor_idx_reg;
            end
            S_RD_WR:
            begin
                res_x_next      = cursor_idx_reg[COORD_W-1:0];
                res_y_next      = cursor_idx_reg[IDX_W-1:COORD_W];
                res_last_next   = !cell_rdata.pvalid;
                cursor_vld_next = cell_rdata.pvalid;
                cursor_idx_next = cell_rdata.parent;
            end
            S_CLR:
            begin
                // read-modify-write sweep that drops all search marks
                if (pend_reg)
                begin
                    nw.is_open   = 1'b0;
                    nw.is_closed = 1'b0;
                    nw.pvalid    = 1'b0;
                    cell_we      = 1'b1;
                    cell_waddr   = pend_addr_reg;
                    cell_wdata   = nw;
                end
                if (!cnt_reg[IDX_W])
                begin
                    cell_re        = 1'b1;
                    cell_raddr     = cnt_reg[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[IDX_W-1:0];
                    cnt_next       = cnt_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_START_RD:
            begin
                cell_re    = 1'b1;
                cell_raddr = ld_idx_reg;
            end
            S_START_WR:
            begin
                nw.is_open   = 1'b1;
                nw.is_closed = 1'b0;
                nw.pvalid    = 1'b0;
                nw.g         = '0;
                nw.f         = h_ext;
                cell_we      = 1'b1;
                cell_waddr   = ld_idx_reg;
                cell_wdata   = nw;
                q_we         = 1'b1;
                q_waddr      = '0;
                q_wdata      = ld_idx_reg;
                count_next   = CNT_W'(1);
            end
            S_CHECK:
            begin
                if (count_reg == '0)
                begin
                    res_status_next = STAT_NO_PATH;
                end
                else
                begin
                    cnt_next    = '0;
                    p1_vld_next = 1'b0;
                    p2_vld_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                // queue read, then cell read, then compare
                if (cnt_reg < count_reg)
                begin
                    q_raddr     = cnt_reg[IDX_W-1:0];
                    p1_vld_next = 1'b1;
                    p1_i_next   = cnt_reg[IDX_W-1:0];
                    cnt_next    = cnt_inc;
                end
                else
                begin
                    p1_vld_next = 1'b0;
                end
                if (p1_vld_reg)
                begin
                    cell_re     = 1'b1;
                    cell_raddr  = q_rdata;
                    p2_vld_next = 1'b1;
                    p2_i_next   = p1_i_reg;
                    p2_idx_next = q_rdata;
                end
                else
                begin
                    p2_vld_next = 1'b0;
                end
                if (p2_vld_reg)
                begin
                    if ((p2_i_reg == '0) || (cell_rdata.f < best_word_reg.f))
                    begin
                        best_i_next    = p2_i_reg;
                        best_idx_next  = p2_idx_reg;
                        best_word_next = cell_rdata;
                    end
                end
                if (scan_done)
                begin
                    cnt_next  = {1'b0, best_i_reg};
                    pend_next = 1'b0;
                end
            end
            S_MOVE:
            begin
                // close the gap left by the picked entry
                if (pend_reg)
                begin
                    q_we    = 1'b1;
                    q_waddr = pend_addr_reg;
                    q_wdata = q_rdata;
                end
                if (move_more)
                begin
                    q_raddr        = cnt_inc[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[IDX_W-1:0];
                    cnt_next       = cnt_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (move_done)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_CLOSE:
            begin
                nw           = best_word_reg;
                nw.is_open   = 1'b0;
                nw.is_closed = 1'b1;
                cell_we      = 1'b1;
                cell_waddr   = best_idx_reg;
                cell_wdata   = nw;
                if (is_goal)
                begin
                    res_cost_next   = OUT_COST_W'({{OUT_COST_W{1'b0}}, best_word_reg.g});
                    cursor_vld_next = 1'b1;
                    cursor_idx_next = best_idx_reg;
                end
                else
                begin
                    k_next  = '0;
                    ok_next = '0;
                end
            end
            S_NB_RD:
            begin
                nb_in_next  = nb_range;
                nb_idx_next = {nb_y8[COORD_W-1:0], nb_x8[COORD_W-1:0]};
                h_next      = octile(nb_x8[COORD_W-1:0], nb_y8[COORD_W-1:0],
                                     goal_x_reg, goal_y_reg);
                if (nb_range)
                begin
                    cell_re    = 1'b1;
                    cell_raddr = {nb_y8[COORD_W-1:0], nb_x8[COORD_W-1:0]};
                end
            end
            S_NB_WR:
            begin
                walk = nb_in_reg && !cell_rdata.blk;
                if (k_reg[2])
                begin
                    // diagonal needs both side tiles walkable
                    ok_k = walk && ok_reg[k_reg[1:0]] && ok_reg[k_reg[1:0] + 2'd1];
                end
                else
                begin
                    ok_k = walk;
                    ok_next[k_reg[1:0]] = walk;
                end
                if (ok_k && !cell_rdata.is_closed)
                begin
                    if (cell_rdata.is_open)
                    begin
                        if (tg < cell_rdata.g)
                        begin
                            nw.g      = tg;
                            nw.pvalid = 1'b1;
                            nw.parent = best_idx_reg;
                        end
                    end
                    else if (count_reg < CNT_W'(CELLS))
                    begin
                        nw.g       = tg;
                        nw.is_open = 1'b1;
                        nw.pvalid  = 1'b1;
                        nw.parent  = best_idx_reg;
                        q_we       = 1'b1;
                        q_waddr    = count_reg[IDX_W-1:0];
                        q_wdata    = nb_idx_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                    nw.f       = sat_add(nw.g, h_ext);
                    cell_we    = 1'b1;
                    cell_waddr = nb_idx_reg;
                    cell_wdata = nw;
                end
                k_next = k_reg + 3'd1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_DATA_W-2*COORD_W-OUT_COST_W){1'b0}},
                             res_cost_reg, res_y_reg, res_x_reg};
            m_tuser_next  = res_status_reg;
            m_tlast_next  = res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            count_reg      <= '0;
            cursor_vld_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            k_reg          <= '0;
            ok_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            p1_vld_reg     <= p1_vld_next;
            p2_vld_reg     <= p2_vld_next;
            count_reg      <= count_next;
            cursor_vld_reg <= cursor_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
            k_reg          <= k_next;
            ok_reg         <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_idx_reg <= cursor_idx_next;
        pend_addr_reg  <= pend_addr_next;
        p1_i_reg       <= p1_i_next;
        p2_i_reg       <= p2_i_next;
        p2_idx_reg     <= p2_idx_next;
        best_i_reg     <= best_i_next;
        best_idx_reg   <= best_idx_next;
        best_word_reg  <= best_word_next;
        ld_idx_reg     <= ld_idx_next;
        ld_blk_reg     <= ld_blk_next;
        goal_x_reg     <= goal_x_next;
        goal_y_reg     <= goal_y_next;
        h_reg          <= h_next;
        nb_in_reg      <= nb_in_next;
        nb_idx_reg     <= nb_idx_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_last_reg   <= res_last_next;
        res_cost_reg   <= res_cost_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CELLS))
        else $error("open count above cell count");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_we && cell_re) |-> (cell_waddr != cell_raddr))
        else $error("cell read and write to same entry in one cycle");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_MOVE) |-> !cell_we)
        else $error("cell store changed during open list walk");

    a_resp_lands: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid_reg && state_reg == S_IDLE))
        else $error("response not presented after load");

endmodule

// ===== hdl/grid_astar_path_search.sv =====
// channel   | dir | fields (low bit first)                             | handshake
// s_t*      | in  | tuser: command; tdata: tile_x, tile_y, blocking,   | tvalid/tready
//           |     |   goal_x, goal_y                                   |
// m_t*      | out | tuser: status; tdata: path_x, path_y, path_cost;   | tvalid/tready
//           |     |   tlast: path_last                                 |
// apb       | in  | map_width at 0x0, map_height at 0x4                | psel/penable
//
// one command at a time, one result per command; a finished result sits in the
// output register while the next command is taken
// load and path read each go accept, cell store read, write back or cursor step, response
// search: a mark clear sweep over the cell store, then per expansion the open list scan,
//   the queue shift, the close of the picked tile, and a read and a write for each of the
//   eight neighbours, all set by the single cell store read port
// reset: a sweep clears the map to walkable with s_tready low
module grid_astar_path_search #(
    parameter int COST_BITS = gaps_pkg::COST_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gaps_pkg::S_DATA_W-1:0] s_tdata,  // tile_x, tile_y, blocking, goal_x, goal_y
    input  logic [gaps_pkg::USER_W-1:0]   s_tuser,  // command
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gaps_pkg::M_DATA_W-1:0] m_tdata,  // path_x, path_y, path_cost
    output logic [gaps_pkg::USER_W-1:0]   m_tuser,  // status
    output logic                          m_tlast,  // path_last
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gaps_pkg::APB_AW-1:0]   paddr,
    input  logic [gaps_pkg::APB_DW-1:0]   pwdata,
    output logic [gaps_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import gaps_pkg::*;

    // active map size, clamped to the store inside the sequencer
    map_cfg_t cfg;

    gaps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer around the cell store and the open queue memory
    gaps_ctrl #(.COST_BITS(COST_BITS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== dv/tb_grid_astar_path_search.sv =====
`timescale 1ns / 1ps

module tb_grid_astar_path_search;
    import gaps_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int CYCLE_CAP  = 30_000_000;
    localparam int ITEM_GOAL  = 1550;
    localparam int COST_SAT   = 131071;

    // one expected transfer on the result stream
    typedef struct {
        status_t     status;
        logic [5:0]  x;
        logic [5:0]  y;
        logic        last;
        logic [16:0] cost;
    } path_result_t;

    // mirror of the tile store and the search state, with the queue of results still due
    class path_scoreboard;
        bit          blocked[CELLS];
        int unsigned g_cost[CELLS];
        int unsigned f_cost[CELLS];
        int unsigned link[CELLS];
        bit          link_ok[CELLS];
        bit          is_open[CELLS];
        bit          is_closed[CELLS];
        int unsigned cursor;
        bit          cursor_ok;
        int unsigned width_eff = 64;
        int unsigned height_eff = 64;
        path_result_t due[$];
        int          errors;

        function void set_dims(int unsigned w, int unsigned h);
            width_eff  = (w > MAP_SIDE) ? MAP_SIDE : w;
            height_eff = (h > MAP_SIDE) ? MAP_SIDE : h;
        endfunction

        function int unsigned octile_dist(int ax, int ay, int bx, int by);
            int dx;
            int dy;
            int lo;
            int hi;
            dx = (ax > bx) ? ax - bx : bx - ax;
            dy = (ay > by) ? ay - by : by - ay;
            lo = (dx < dy) ? dx : dy;
            hi = (dx < dy) ? dy : dx;
            return STEP_DIAG * lo + STEP_ORTHO * (hi - lo);
        endfunction

        function bit free_tile(int x, int y);
            if (x < 0 || y < 0 || x >= int'(width_eff) || y >= int'(height_eff))
                return 0;
            return !blocked[y * MAP_SIDE + x];
        endfunction

        function int unsigned sat_add(int unsigned a, int unsigned b);
            return (a + b > COST_SAT) ? COST_SAT : a + b;
        endfunction

        // a* with insertion-ordered open list, first lowest f wins
        function status_t run_search(int sx, int sy, int gx, int gy,
                                     output int unsigned goal_cost);
            int unsigned open_list[$];
            int          ddx[8] = '{0, 1, 0, -1, 1, 1, -1, -1};
            int          ddy[8] = '{-1, 0, 1, 0, -1, 1, 1, -1};
            bit          ok[8];
            int          best;
            int unsigned cur;
            int unsigned start_i;
            int unsigned goal_i;
            int unsigned n;
            int unsigned tg;
            int          cx;
            int          cy;
            int          nx;
            int          ny;
            start_i = sy * MAP_SIDE + sx;
            goal_i  = gy * MAP_SIDE + gx;
            goal_cost = 0;
            foreach (is_open[i])
            begin
                is_open[i]   = 0;
                is_closed[i] = 0;
                link_ok[i]   = 0;
            end
            g_cost[start_i] = 0;
            f_cost[start_i] = octile_dist(sx, sy, gx, gy);
            open_list.insert(open_list.size(), start_i);
            is_open[start_i] = 1;
            while (open_list.size() > 0)
            begin
                best = 0;
                for (int i = 1; i < open_list.size(); i++)
                    if (f_cost[open_list[i]] < f_cost[open_list[best]])
                        best = i;
                cur = open_list[best];
                open_list.delete(best);
                is_open[cur]   = 0;
                is_closed[cur] = 1;
                if (cur == goal_i)
                begin
                    goal_cost = g_cost[cur];
                    return STAT_OK;
                end
                cx = cur % MAP_SIDE;
                cy = cur / MAP_SIDE;
                for (int k = 0; k < 8; k++)
                    ok[k] = free_tile(cx + ddx[k], cy + ddy[k]);
                // no corner cutting past a blocked orthogonal tile
                ok[4] = ok[4] && ok[0] && ok[1];
                ok[5] = ok[5] && ok[1] && ok[2];
                ok[6] = ok[6] && ok[2] && ok[3];
                ok[7] = ok[7] && ok[3] && ok[0];
                for (int k = 0; k < 8; k++)
                begin
                    if (!ok[k])
                        continue;
                    nx = cx + ddx[k];
                    ny = cy + ddy[k];
                    n  = ny * MAP_SIDE + nx;
                    if (is_closed[n])
                        continue;
                    tg = sat_add(g_cost[cur], (k < 4) ? STEP_ORTHO : STEP_DIAG);
                    if (is_open[n])
                    begin
                        if (tg < g_cost[n])
                        begin
                            g_cost[n]  = tg;
                            link[n]    = cur;
                            link_ok[n] = 1;
                        end
                    end
                    else
                    begin
                        g_cost[n] = tg;
                        open_list.insert(open_list.size(), n);
                        is_open[n] = 1;
                        link[n]    = cur;
                        link_ok[n] = 1;
                    end
                    f_cost[n] = sat_add(g_cost[n], octile_dist(nx, ny, gx, gy));
                end
            end
            return STAT_NO_PATH;
        endfunction

        // called on each accepted command transfer
        function void note_command(cmd_t cmd, logic [5:0] tx, logic [5:0] ty, logic blk,
                                   logic [5:0] gx, logic [5:0] gy);
            path_result_t r;
            int unsigned  c;
            r = '{STAT_OK, 6'd0, 6'd0, 1'b0, 17'd0};
            case (cmd)
                CMD_LOAD:
                    blocked[ty * MAP_SIDE + tx] = blk;
                CMD_SEARCH:
                begin
                    cursor_ok = 0;
                    if (tx >= width_eff || ty >= height_eff || gx >= width_eff ||
                        gy >= height_eff)
                        r.status = STAT_RANGE;
                    else
                    begin
                        r.status = run_search(tx, ty, gx, gy, c);
                        if (r.status == STAT_OK)
                        begin
                            r.cost    = c[16:0];
                            cursor    = gy * MAP_SIDE + gx;
                            cursor_ok = 1;
                        end
                    end
                end
                CMD_READ:
                begin
                    if (!cursor_ok)
                        r.status = STAT_END;
                    else
                    begin
                        r.x       = 6'(cursor % MAP_SIDE);
                        r.y       = 6'(cursor / MAP_SIDE);
                        r.last    = !link_ok[cursor];
                        cursor_ok = link_ok[cursor];
                        cursor    = link[cursor];
                    end
                end
                default: ;
            endcase
            due.insert(due.size(), r);
        endfunction

        // tiles left to read on the current path
        function int path_left();
            int          cnt;
            int unsigned c;
            if (!cursor_ok)
                return 0;
            cnt = 1;
            c   = cursor;
            while (link_ok[c])
            begin
                c = link[c];
                cnt++;
            end
            return cnt;
        endfunction

        function void check_result(path_result_t got);
            path_result_t exp_r;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result with nothing due: status %0d x %0d y %0d",
                             got.status, got.x, got.y);
                return;
            end
            exp_r = due.pop_front();
            if (got.status !== exp_r.status || got.x !== exp_r.x || got.y !== exp_r.y ||
                got.last !== exp_r.last || got.cost !== exp_r.cost)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $write("mismatch: exp st %0d x %0d y %0d last %0d cost %0d, ",
                           exp_r.status, exp_r.x, exp_r.y, exp_r.last, exp_r.cost);
                    $display("got st %0d x %0d y %0d last %0d cost %0d",
                             got.status, got.x, got.y, got.last, got.cost);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [USER_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [USER_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    path_scoreboard path_sb;
    int             cycle_count = 0;
    int             cmd_sent;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_left;

    grid_astar_path_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // tile_x, tile_y, blocking, goal_x, goal_y
        .s_tuser  (s_tuser),   // command
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // path_x, path_y, path_cost
        .m_tuser  (m_tuser),   // status
        .m_tlast  (m_tlast),   // path_last
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check each transfer, then pick next tready
    // a long hold-off is counted down here when requested
    initial
    begin
        path_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tuser);
                got.x      = m_tdata[5:0];
                got.y      = m_tdata[11:6];
                got.cost   = m_tdata[28:12];
                got.last   = m_tlast;
                path_sb.check_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !($urandom_range(99) < recv_stall_pct);
        end
    end

    // one command transfer, with random gaps before it
    task automatic send_cmd(cmd_t cmd, logic [5:0] tx, logic [5:0] ty, logic blk,
                            logic [5:0] gx, logic [5:0] gy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, gy, gx, blk, ty, tx};
        do
            @(posedge clk);
        while (!s_tready);
        path_sb.note_command(cmd, tx, ty, blk, gx, gy);
        cmd_sent++;
    endtask

    // sender pauses until every result is back; block is idle afterwards
    task automatic drain();
        s_tvalid <= 1'b0;
        while (path_sb.due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_map(int unsigned w, int unsigned h);
        drain();
        reg_write(REG_MAP_WIDTH, w);
        reg_write(REG_MAP_HEIGHT, h);
        path_sb.set_dims(w, h);
    endtask

    task automatic read_path(int extra);
        int n;
        n = path_sb.path_left() + extra;
        repeat (n)
            send_cmd(CMD_READ, $urandom_range(63), $urandom_range(63), $urandom_range(1),
                     $urandom_range(63), $urandom_range(63));
    endtask

    function automatic logic [5:0] pick_coord(int unsigned lim);
        if (lim == 0 || $urandom_range(9) == 0)
            return $urandom_range(63);
        return $urandom_range(lim - 1);
    endfunction

    // loads around the active area, then a search and a walk of its path
    task automatic run_episode();
        int unsigned w;
        int unsigned h;
        bit          wide;
        logic [5:0]  sx;
        logic [5:0]  sy;
        logic [5:0]  gx;
        logic [5:0]  gy;
        int          t;
        w    = path_sb.width_eff;
        h    = path_sb.height_eff;
        wide = (w * h > 256);
        repeat ($urandom_range(wide ? 3 : 7))
            send_cmd(CMD_LOAD, pick_coord(w), pick_coord(h), $urandom_range(99) < 35,
                     $urandom_range(63), $urandom_range(63));
        sx = pick_coord(w);
        sy = pick_coord(h);
        gx = pick_coord(w);
        gy = pick_coord(h);
        if (wide)
        begin
            // keep large-map searches local, with an open goal tile
            t  = int'(sx) + $urandom_range(12) - 6;
            gx = (t < 0) ? 0 : (t >= int'(w)) ? w - 1 : t;
            t  = int'(sy) + $urandom_range(12) - 6;
            gy = (t < 0) ? 0 : (t >= int'(h)) ? h - 1 : t;
            send_cmd(CMD_LOAD, gx, gy, 1'b0, $urandom_range(63), $urandom_range(63));
        end
        if ($urandom_range(19) == 0)
            send_cmd(CMD_NONE, $urandom_range(63), $urandom_range(63), $urandom_range(1),
                     $urandom_range(63), $urandom_range(63));
        send_cmd(CMD_SEARCH, sx, sy, $urandom_range(1), gx, gy);
        read_path($urandom_range(1));
    endtask

    initial
    begin
        int unsigned cfg_w[8] = '{8, 1, 5, 16, 0, 127, 64, 12};
        int unsigned cfg_h[8] = '{8, 1, 12, 16, 3, 2, 64, 7};
        int          phase_end;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_sent       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        path_sb        = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no path yet, start equals a blocked goal at the far corner,
        // unused command, blocked start
        send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0);
        send_cmd(CMD_LOAD, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63);
        send_cmd(CMD_SEARCH, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63);
        read_path(1);
        send_cmd(CMD_NONE, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63);
        send_cmd(CMD_LOAD, 6'd0, 6'd0, 1'b1, 6'd0, 6'd0);
        send_cmd(CMD_SEARCH, 6'd0, 6'd0, 1'b0, 6'd3, 6'd2);
        read_path(1);

        // small map: start or goal out of range, blocked goal, load outside the map
        set_map(8, 8);
        send_cmd(CMD_SEARCH, 6'd9, 6'd0, 1'b0, 6'd1, 6'd1);
        send_cmd(CMD_SEARCH, 6'd1, 6'd1, 1'b0, 6'd0, 6'd8);
        send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0);
        send_cmd(CMD_LOAD, 6'd5, 6'd5, 1'b1, 6'd0, 6'd0);
        send_cmd(CMD_SEARCH, 6'd4, 6'd4, 1'b0, 6'd5, 6'd5);
        send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0);
        send_cmd(CMD_LOAD, 6'd5, 6'd5, 1'b0, 6'd0, 6'd0);
        send_cmd(CMD_LOAD, 6'd40, 6'd50, 1'b1, 6'd0, 6'd0);
        send_cmd(CMD_LOAD, 6'd40, 6'd50, 1'b0, 6'd0, 6'd0);
        send_cmd(CMD_LOAD, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0);
        send_cmd(CMD_LOAD, 6'd63, 6'd63, 1'b0, 6'd0, 6'd0);

        for (int p = 0; p < 8; p++)
        begin
            set_map(cfg_w[p], cfg_h[p]);
            send_idle_pct  = (p % 4 == 1) ? 61 : (p % 4 == 3) ? 27 : 0;
            recv_stall_pct = (p % 4 == 2) ? 61 : (p % 4 == 3) ? 27 : 0;
            if (p == 2)
            begin
                // receiver holds off while loads keep coming, so the input backs up
                hold_left = 400;
                repeat (40)
                    send_cmd(CMD_LOAD, pick_coord(cfg_w[p]), pick_coord(cfg_h[p]),
                             $urandom_range(1), $urandom_range(63), $urandom_range(63));
            end
            phase_end = ITEM_GOAL * (p + 1) / 8;
            while (cmd_sent < phase_end)
                run_episode();
        end

        drain();
        repeat (50) @(posedge clk);
        if (path_sb.errors == 0 && path_sb.due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
